[design/hid_keyboard_report_decoder_unit_macros.svh]
// Assertion helpers shared by the checker.
`ifndef HID_KEYBOARD_REPORT_DECODER_UNIT_MACROS_SVH
`define HID_KEYBOARD_REPORT_DECODER_UNIT_MACROS_SVH

// Implication checked while out of reset.
`define HKRD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also active across reset.
`define HKRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[design/hkrd_pkg.sv]
package hkrd_pkg;

  localparam int MAX_SLOTS      = 6;
  localparam int QUEUE_DEPTH    = 2;
  localparam int MIN_REPORT     = 8;
  localparam int RESERVED_TOP   = 3;

  localparam logic [7:0] CODE_ENTER    = 8'd40;
  localparam logic [7:0] CODE_PAD_ENTER = 8'd88;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // left shift is bit 1, right shift is bit 5
  localparam logic [7:0] SHIFT_MASK = 8'h22;

  localparam logic [7:0] PUNCT_PLAIN [13] = '{
    8'h20, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h5C, 8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E, 8'h2F
  };
  localparam logic [7:0] PUNCT_SHIFT [13] = '{
    8'h20, 8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C, 8'h7C, 8'h3A, 8'h22, 8'h7E, 8'h3C, 8'h3E, 8'h3F
  };
  localparam logic [7:0] DIGIT_SHIFT [10] = '{
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29
  };
  localparam logic [7:0] ARROW_CHARS [4] = '{8'h52, 8'h4C, 8'h44, 8'h55};
  localparam logic [7:0] PAD_OPS     [4] = '{8'h2F, 8'h2A, 8'h2D, 8'h2B};

  typedef struct packed {
    logic full;
    logic empty;
  } hkrd_qstat_t;

  // US layout usage code to ASCII; zero when the code has no character.
  function automatic logic [7:0] translate(input logic [7:0] code, input logic shift);
    logic [7:0] ofs_letter;
    logic [7:0] ofs_digit;
    logic [7:0] ofs_punct;
    logic [7:0] ofs_arrow;
    logic [7:0] ofs_pad;
    logic [7:0] ofs_kp;
    logic [7:0] ch;
    ofs_letter = code - 8'd4;
    ofs_digit  = code - 8'd30;
    ofs_punct  = code - 8'd44;
    ofs_arrow  = code - 8'd79;
    ofs_pad    = code - 8'd84;
    ofs_kp     = code - 8'd89;
    case (code) inside
      [8'd4:8'd29]: ch = (shift ? CH_UP_A : CH_LOW_A) + ofs_letter;
      [8'd30:8'd38]: ch = shift ? DIGIT_SHIFT[ofs_digit[3:0]] : CH_ONE + ofs_digit;
      8'd39: ch = shift ? DIGIT_SHIFT[ofs_digit[3:0]] : CH_ZERO;
      8'd40, 8'd88: ch = CH_CR;
      8'd42, 8'd76: ch = shift ? 8'd0 : CH_BS;
      [8'd44:8'd56]: ch = shift ? PUNCT_SHIFT[ofs_punct[3:0]] : PUNCT_PLAIN[ofs_punct[3:0]];
      [8'd79:8'd82]: ch = ARROW_CHARS[ofs_arrow[1:0]];
      [8'd84:8'd87]: ch = PAD_OPS[ofs_pad[1:0]];
      [8'd89:8'd97]: ch = CH_ONE + ofs_kp;
      8'd98: ch = CH_ZERO;
      8'd99: ch = shift ? CH_DOT : CH_BS;
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

[design/hid_keyboard_report_decoder_unit.sv]
// A report's first event passes the report queue, event sequencer and result register.
// Throughput: one event per cycle while pop is held within a report; the sequencer loads
//   a report only after the last event of the one before, and reports with no event skip it.
// Reports enter every cycle while the 2-entry report queue has room.
// Reset (rst, synchronous): held codes cleared, lf_after_enter set to 1,
//   queue and result register emptied.
module hid_keyboard_report_decoder_unit #(
  parameter int KEY_SLOTS = hkrd_pkg::MAX_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  modifier_bits,
  input  logic [7:0]  slot0_code,
  input  logic [7:0]  slot1_code,
  input  logic [7:0]  slot2_code,
  input  logic [7:0]  slot3_code,
  input  logic [7:0]  slot4_code,
  input  logic [7:0]  slot5_code,
  input  logic [6:0]  report_bytes,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  event_code,
  output logic        is_release,
  output logic [7:0]  ascii_char,
  output logic        char_valid,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ENTRY_W = 19 * KEY_SLOTS + 1;

  logic [hkrd_pkg::MAX_SLOTS-1:0][7:0] all_slots;
  logic [KEY_SLOTS-1:0][7:0]           fresh;
  logic                                lf_after_enter;

  hkrd_pkg::hkrd_qstat_t     qstat;
  logic                      q_push;
  logic                      q_pop;
  logic [KEY_SLOTS-1:0][7:0] f_old;
  logic [KEY_SLOTS-1:0][7:0] f_cur;
  logic [3*KEY_SLOTS-1:0]    f_mask;
  logic                      f_shift;
  logic [KEY_SLOTS-1:0][7:0] b_old;
  logic [KEY_SLOTS-1:0][7:0] b_cur;
  logic [3*KEY_SLOTS-1:0]    b_mask;
  logic                      b_shift;
  logic [ENTRY_W-1:0]        wr_data;
  logic [ENTRY_W-1:0]        rd_data;

  assign all_slots = {slot5_code, slot4_code, slot3_code, slot2_code, slot1_code, slot0_code};
  assign fresh     = all_slots[KEY_SLOTS-1:0];

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {31'd0, lf_after_enter} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lf_after_enter <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      lf_after_enter <= pwdata[0];
    end
  end

  hkrd_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .modifier_bits  (modifier_bits),
    .fresh          (fresh),
    .report_bytes   (report_bytes),
    .lf_after_enter (lf_after_enter),
    .qstat          (qstat),
    .q_push         (q_push),
    .q_old          (f_old),
    .q_cur          (f_cur),
    .q_mask         (f_mask),
    .q_shift        (f_shift)
  );

  assign wr_data = {f_old, f_cur, f_mask, f_shift};
  assign {b_old, b_cur, b_mask, b_shift} = rd_data;

  hkrd_queue #(.WIDTH(ENTRY_W), .DEPTH(hkrd_pkg::QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (wr_data),
    .rd_en   (q_pop),
    .rd_data (rd_data),
    .qstat   (qstat)
  );

  hkrd_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .q_old       (b_old),
    .q_cur       (b_cur),
    .q_mask      (b_mask),
    .q_shift     (b_shift),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .event_code  (event_code),
    .is_release  (is_release),
    .ascii_char  (ascii_char),
    .char_valid  (char_valid),
    .last_of_run (last_of_run)
  );

endmodule

[design/hkrd_front.sv]
module hkrd_front #(
  parameter int KEY_SLOTS = hkrd_pkg::MAX_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      modifier_bits,
  input  logic [KEY_SLOTS-1:0][7:0]       fresh,
  input  logic [6:0]                      report_bytes,
  input  logic                            lf_after_enter,
  input  hkrd_pkg::hkrd_qstat_t           qstat,
  output logic                            q_push,
  output logic [KEY_SLOTS-1:0][7:0]       q_old,
  output logic [KEY_SLOTS-1:0][7:0]       q_cur,
  output logic [3*KEY_SLOTS-1:0]          q_mask,
  output logic                            q_shift
);

  logic [KEY_SLOTS-1:0][7:0] held_codes;
  logic                      accept;
  logic                      long_enough;
  logic [KEY_SLOTS-1:0]      old_seen;
  logic [KEY_SLOTS-1:0]      cur_seen;

  assign full        = qstat.full;
  assign accept      = push && !qstat.full;
  assign long_enough = report_bytes >= 7'(hkrd_pkg::MIN_REPORT);

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      old_seen[i] = 1'b0;
      cur_seen[i] = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (fresh[j] == held_codes[i]) begin
          old_seen[i] = 1'b1;
        end
        if (held_codes[j] == fresh[i]) begin
          cur_seen[i] = 1'b1;
        end
      end
    end
  end

  // per slot: release, press, line feed, in emission order
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      q_mask[3*i]   = (held_codes[i] > 8'(hkrd_pkg::RESERVED_TOP)) && !old_seen[i];
      q_mask[3*i+1] = (fresh[i] > 8'(hkrd_pkg::RESERVED_TOP)) && !cur_seen[i];
      q_mask[3*i+2] = q_mask[3*i+1] && lf_after_enter &&
                      (fresh[i] == hkrd_pkg::CODE_ENTER || fresh[i] == hkrd_pkg::CODE_PAD_ENTER);
    end
  end

  assign q_old   = held_codes;
  assign q_cur   = fresh;
  assign q_shift = |(modifier_bits & hkrd_pkg::SHIFT_MASK);
  // reports that cause no event never reach the queue
  assign q_push  = accept && long_enough && (|q_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_codes <= '0;
    end else if (accept && long_enough) begin
      held_codes <= fresh;
    end
  end

endmodule

[design/hkrd_queue.sv]
module hkrd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hkrd_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [WIDTH-1:0]      wr_data,
  input  logic                  rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output hkrd_pkg::hkrd_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign qstat.full  = count == CNT_W'(DEPTH);
  assign qstat.empty = count == '0;
  assign do_wr       = wr_en && !qstat.full;
  assign do_rd       = rd_en && !qstat.empty;
  assign rd_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/hkrd_back.sv]
module hkrd_back #(
  parameter int KEY_SLOTS = hkrd_pkg::MAX_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hkrd_pkg::hkrd_qstat_t      qstat,
  input  logic [KEY_SLOTS-1:0][7:0]  q_old,
  input  logic [KEY_SLOTS-1:0][7:0]  q_cur,
  input  logic [3*KEY_SLOTS-1:0]     q_mask,
  input  logic                       q_shift,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [7:0]                 event_code,
  output logic                       is_release,
  output logic [7:0]                 ascii_char,
  output logic                       char_valid,
  output logic                       last_of_run
);

  localparam int MASK_W = 3 * KEY_SLOTS;

  logic                      active;
  logic [KEY_SLOTS-1:0][7:0] old_codes;
  logic [KEY_SLOTS-1:0][7:0] cur_codes;
  logic [MASK_W-1:0]         mask;
  logic                      shift;
  logic                      out_valid;

  logic [MASK_W-1:0] low;
  logic [MASK_W-1:0] rest;
  logic [7:0]        sel_old;
  logic [7:0]        sel_cur;
  logic              kind_rel;
  logic              kind_lf;
  logic              advance;
  logic [7:0]        press_char;
  logic [7:0]        code_next;
  logic [7:0]        char_next;

  assign low  = mask & (~mask + 1'b1);
  assign rest = mask & ~low;

  always_comb begin
    sel_old  = '0;
    sel_cur  = '0;
    kind_rel = 1'b0;
    kind_lf  = 1'b0;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      if (|low[3*s +: 3]) begin
        sel_old  = old_codes[s];
        sel_cur  = cur_codes[s];
        kind_rel = low[3*s];
        kind_lf  = low[3*s+2];
      end
    end
  end

  assign press_char = hkrd_pkg::translate(sel_cur, shift);
  assign code_next  = kind_rel ? sel_old : sel_cur;
  assign char_next  = kind_rel ? 8'd0 : (kind_lf ? hkrd_pkg::CH_LF : press_char);

  assign advance = active && (!out_valid || pop);
  assign q_pop   = !active && !qstat.empty;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      old_codes <= q_old;
      cur_codes <= q_cur;
      shift     <= q_shift;
    end
    if (q_pop) begin
      mask <= q_mask;
    end else if (advance) begin
      mask <= rest;
    end
    if (advance) begin
      event_code  <= code_next;
      is_release  <= kind_rel;
      ascii_char  <= char_next;
      char_valid  <= char_next != 8'd0;
      last_of_run <= rest == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (advance && rest == '0) begin
        active <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/hkrd_checker.sv]
`include "hid_keyboard_report_decoder_unit_macros.svh"

module hkrd_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] event_code,
  input logic       is_release,
  input logic [7:0] ascii_char,
  input logic       char_valid
);

  `HKRD_ASSERT_NEXT(a_reset_idle, rst, empty && !full, "not idle after reset")
  `HKRD_ASSERT_IMPL(a_release_no_char, !empty && is_release,
                    !char_valid && ascii_char == 8'd0, "release carries a character")
  `HKRD_ASSERT_IMPL(a_char_valid, !empty, char_valid == (ascii_char != 8'd0),
                    "char_valid disagrees with ascii_char")
  `HKRD_ASSERT_IMPL(a_stall_hold, $past(!empty && !pop) && !$past(rst),
                    !empty && $stable(event_code) && $stable(ascii_char),
                    "stalled result changed")

endmodule

bind hid_keyboard_report_decoder_unit hkrd_checker u_hkrd_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .event_code (event_code),
  .is_release (is_release),
  .ascii_char (ascii_char),
  .char_valid (char_valid)
);

[test/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SLOTS        = 6;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         RANDOM_ITEMS = 144;
  localparam logic [2:0] ADDR_LF_AFTER_ENTER = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED       = 3'd4;

  localparam logic [7:0] KEY_ENTER     = 8'd40;
  localparam logic [7:0] KEY_PAD_ENTER = 8'd88;
  localparam logic [7:0] ASCII_CR = 8'h0D;
  localparam logic [7:0] ASCII_LF = 8'h0A;
  localparam logic [7:0] ASCII_BS = 8'h08;

  localparam logic [8*13-1:0] SHIFTED_DIGITS = "!@#$%^&*()";
  localparam logic [8*13-1:0] PUNCT_LOWER    = " -=[]\\\\;'`,./";
  localparam logic [8*13-1:0] PUNCT_UPPER    = " _+{}||:\"~<>?";
  localparam logic [8*13-1:0] ARROW_LETTERS  = "RLDU";
  localparam logic [8*13-1:0] PAD_SIGNS      = "/*-+";

  typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_e;

  typedef struct packed {
    logic [7:0]      mods;
    logic [5:0][7:0] keys;
    logic [6:0]      len;
  } report_t;

  typedef struct packed {
    logic [7:0] code;
    logic       release_evt;
    logic [7:0] ch;
    logic       ch_valid;
    logic       last;
  } kbd_event_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  modifier_bits;
  logic [7:0]  slot0_code, slot1_code, slot2_code, slot3_code, slot4_code, slot5_code;
  logic [6:0]  report_bytes;
  logic        empty;
  logic        pop;
  logic [7:0]  event_code;
  logic        is_release;
  logic [7:0]  ascii_char;
  logic        char_valid;
  logic        last_of_run;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hid_keyboard_report_decoder_unit i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .modifier_bits(modifier_bits),
    .slot0_code(slot0_code), .slot1_code(slot1_code), .slot2_code(slot2_code),
    .slot3_code(slot3_code), .slot4_code(slot4_code), .slot5_code(slot5_code),
    .report_bytes(report_bytes),
    .empty(empty), .pop(pop),
    .event_code(event_code), .is_release(is_release), .ascii_char(ascii_char),
    .char_valid(char_valid), .last_of_run(last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [7:0] held_keys [SLOTS];
  logic       lf_enabled;
  kbd_event_t pending_events[$];
  int         mismatch_count;
  int         burst_left;
  int         idle_cycles;
  logic [5:0][7:0] typed_keys;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] char_at(logic [8*13-1:0] s, int n, int i);
    return s[8*(n-1-i) +: 8];
  endfunction

  // US layout; zero means no printable character
  function automatic logic [7:0] key_to_char(logic [7:0] code, logic shifted);
    int c;
    c = code;
    if (c >= 4 && c <= 29) return 8'((shifted ? "A" : "a") + c - 4);
    if (c >= 30 && c <= 39) begin
      if (shifted) return char_at(SHIFTED_DIGITS, 10, c - 30);
      return (c == 39) ? 8'("0") : 8'("1" + c - 30);
    end
    if (code == KEY_ENTER || code == KEY_PAD_ENTER) return ASCII_CR;
    if (c == 42 || c == 76) return shifted ? 8'd0 : ASCII_BS;
    if (c >= 44 && c <= 56)
      return shifted ? char_at(PUNCT_UPPER, 13, c - 44) : char_at(PUNCT_LOWER, 13, c - 44);
    if (c >= 79 && c <= 82) return char_at(ARROW_LETTERS, 4, c - 79);
    if (c >= 84 && c <= 87) return char_at(PAD_SIGNS, 4, c - 84);
    if (c >= 89 && c <= 97) return 8'("1" + c - 89);
    if (c == 98) return 8'("0");
    if (c == 99) return shifted ? 8'(".") : ASCII_BS;
    return 8'd0;
  endfunction

  function automatic void add_event(logic [7:0] code, logic rel, logic [7:0] ch);
    kbd_event_t e;
    e.code        = code;
    e.release_evt = rel;
    e.ch          = ch;
    e.ch_valid    = (ch != 8'd0);
    e.last        = 1'b0;
    pending_events.push_back(e);
  endfunction

  // expected key events for one accepted report, in slot order
  function automatic void decode_report(report_t r);
    logic shifted;
    logic found_old, found_new;
    logic [7:0] ch;
    int first;
    if (r.len < 7'd8) return;
    shifted = r.mods[1] | r.mods[5];
    first = pending_events.size();
    for (int i = 0; i < SLOTS; i++) begin
      found_old = 1'b0;
      found_new = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
        if (r.keys[j] == held_keys[i]) found_old = 1'b1;
        if (held_keys[j] == r.keys[i]) found_new = 1'b1;
      end
      if (held_keys[i] > 8'd3 && !found_old) add_event(held_keys[i], 1'b1, 8'd0);
      if (r.keys[i] > 8'd3 && !found_new) begin
        ch = key_to_char(r.keys[i], shifted);
        add_event(r.keys[i], 1'b0, ch);
        if (ch == ASCII_CR && lf_enabled) add_event(r.keys[i], 1'b0, ASCII_LF);
      end
    end
    for (int i = 0; i < SLOTS; i++) held_keys[i] = r.keys[i];
    if (pending_events.size() > first) pending_events[$].last = 1'b1;
  endfunction

  function automatic void note_mismatch(string what);
    if (mismatch_count < 10) $display("MISMATCH %s", what);
    mismatch_count++;
  endfunction

  function automatic report_t make_report(logic [7:0] mods, logic [7:0] k0, logic [7:0] k1,
                                          logic [7:0] k2, logic [7:0] k3, logic [7:0] k4,
                                          logic [7:0] k5, logic [6:0] len);
    report_t r;
    r.mods = mods;
    r.keys = {k5, k4, k3, k2, k1, k0};
    r.len  = len;
    return r;
  endfunction

  task automatic send_report(report_t r);
    push          <= 1'b1;
    modifier_bits <= r.mods;
    slot0_code    <= r.keys[0];
    slot1_code    <= r.keys[1];
    slot2_code    <= r.keys[2];
    slot3_code    <= r.keys[3];
    slot4_code    <= r.keys[4];
    slot5_code    <= r.keys[5];
    report_bytes  <= r.len;
    do @(posedge clk); while (full);
    decode_report(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
    end
  endtask

  // drain all expected events, then let the unit settle
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (wr && addr == ADDR_LF_AFTER_ENTER) lf_enabled = data[0];
    @(posedge clk);
  endtask

  task automatic write_lf(logic [2:0] addr, logic value);
    logic [31:0] dummy;
    logic [31:0] rdata;
    wait_idle();
    apb_access(1'b1, addr, {31'($urandom_range(0, 32'h7FFF_FFFF)), value}, dummy);
    apb_access(1'b0, ADDR_LF_AFTER_ENTER, 32'd0, rdata);
    if (rdata !== {31'd0, lf_enabled})
      note_mismatch($sformatf("lf_after_enter readback: expected %0d got %h",
                              lf_enabled, rdata));
  endtask

  task automatic test_register_default();
    logic [31:0] rdata;
    apb_access(1'b0, ADDR_LF_AFTER_ENTER, 32'd0, rdata);
    if (rdata !== 32'd1)
      note_mismatch($sformatf("lf_after_enter after reset: expected 1 got %h", rdata));
  endtask

  task automatic test_directed_keys();
    send_report(make_report(8'h00, 4, 5, 6, 7, 8, 9, 7'd7));    // too short
    send_report(make_report(8'hFF, 40, 0, 0, 0, 0, 0, 7'd0));
    send_report(make_report(8'h00, 4, 5, 0, 0, 0, 0, 7'd8));
    send_report(make_report(8'h02, 4, 5, 29, 0, 0, 0, 7'd8));   // left shift
    send_report(make_report(8'h20, 30, 39, 0, 0, 0, 0, 7'd9));  // right shift
    send_report(make_report(8'hDD, 30, 39, 31, 38, 0, 0, 7'd8)); // no shift bit
    send_report(make_report(8'h00, KEY_ENTER, KEY_PAD_ENTER, 0, 0, 0, 0, 7'd64));
    send_report(make_report(8'h00, 42, 76, 99, 44, 56, 49, 7'd8));
    send_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, 7'd8));
    send_report(make_report(8'h22, 42, 76, 99, 45, 55, 53, 7'd8));
    send_report(make_report(8'h00, 79, 82, 84, 87, 89, 98, 7'd8));
    send_report(make_report(8'h00, 97, 112, 113, 255, 100, 0, 7'd8)); // keypad 9, then untranslated codes
    send_report(make_report(8'h00, 1, 2, 3, 0, 0, 0, 7'd8));   // reserved codes
    send_report(make_report(8'h00, 4, 4, 4, 3, 0, 0, 7'd8));   // repeated code
    send_report(make_report(8'h00, 4, 5, 6, 7, 8, 9, 7'd8));
    // every slot releases, presses Enter and adds a line feed
    send_report(make_report(8'h00, KEY_ENTER, KEY_ENTER, KEY_ENTER, KEY_ENTER,
                            KEY_ENTER, KEY_ENTER, 7'd8));
    send_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, 7'd8));
  endtask

  task automatic test_line_feed_setting();
    write_lf(ADDR_LF_AFTER_ENTER, 1'b0);
    send_report(make_report(8'h00, KEY_ENTER, KEY_PAD_ENTER, 0, 0, 0, 0, 7'd8));
    send_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, 7'd8));
    write_lf(ADDR_UNMAPPED, 1'b1);                              // no effect
    send_report(make_report(8'h00, KEY_PAD_ENTER, 0, 0, 0, 0, 0, 7'd8));
    send_report(make_report(8'h00, 0, 0, 0, 0, 0, 0, 7'd8));
    write_lf(ADDR_LF_AFTER_ENTER, 1'b1);
    send_report(make_report(8'h00, 0, KEY_PAD_ENTER, 0, 0, 0, 0, 7'd8));
  endtask

  function automatic logic [7:0] typing_code();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 8'($urandom_range(4, 112));
    if (p < 80) return ($urandom_range(0, 1) == 1) ? KEY_ENTER : KEY_PAD_ENTER;
    if (p < 88) return 8'd0;
    if (p < 93) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(113, 255));
  endfunction

  // mostly key-by-key typing on a held set, some noise and short reports
  task automatic test_random_typing(int count);
    report_t r;
    int kind;
    int done;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        r = report_t'(63'({$urandom, $urandom}));
        r.len = 7'($urandom_range(0, 64));
      end else if (kind == 1) begin
        r = report_t'(63'({$urandom, $urandom}));
        r.len = 7'($urandom_range(0, 7));
      end else begin
        repeat ($urandom_range(1, 2)) typed_keys[$urandom_range(0, SLOTS-1)] = typing_code();
        if ($urandom_range(0, 9) == 0)
          typed_keys[$urandom_range(0, SLOTS-1)] = typed_keys[$urandom_range(0, SLOTS-1)];
        if ($urandom_range(0, 19) == 0) typed_keys = '0;
        r.keys = typed_keys;
        r.mods = 8'($urandom_range(0, 255));
        r.len  = 7'($urandom_range(8, 64));
      end
      send_report(r);
      if (r.len >= 7'd8) done++;
    end
  endtask

  // receiver: pop pattern changes mode at random
  initial begin : rx_stall
    rx_mode_e mode;
    int left;
    pop <= 1'b0;
    mode = RX_STREAM;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(8, 60);
      end
      left--;
      case (mode)
        RX_STREAM: pop <= 1'b1;
        RX_RANDOM: pop <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: pop <= (left % 4 == 0);
        default:   pop <= (left < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    kbd_event_t got, want;
    if (!rst && pop && !empty) begin
      got = {event_code, is_release, ascii_char, char_valid, last_of_run};
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("event with none expected: code=%0d rel=%0d ch=%h v=%0d last=%0d",
                                got.code, got.release_evt, got.ch, got.ch_valid, got.last));
      end else begin
        want = pending_events.pop_front();
        if (got.code !== want.code || got.release_evt !== want.release_evt ||
            got.ch !== want.ch || got.ch_valid !== want.ch_valid || got.last !== want.last)
          note_mismatch($sformatf({"expected code=%0d rel=%0d ch=%h v=%0d last=%0d, ",
                                   "got code=%0d rel=%0d ch=%h v=%0d last=%0d"},
                                  want.code, want.release_evt, want.ch, want.ch_valid,
                                  want.last, got.code, got.release_evt, got.ch,
                                  got.ch_valid, got.last));
      end
    end
  end

  // watchdog: cycles without any request moving
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("hid_keyboard_report_decoder_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    push          <= 1'b0;
    modifier_bits <= '0;
    slot0_code    <= '0;
    slot1_code    <= '0;
    slot2_code    <= '0;
    slot3_code    <= '0;
    slot4_code    <= '0;
    slot5_code    <= '0;
    report_bytes  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    mismatch_count = 0;
    burst_left     = 0;
    lf_enabled     = 1'b1;
    typed_keys     = '0;
    for (int i = 0; i < SLOTS; i++) held_keys[i] = 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_default();
    test_directed_keys();
    test_line_feed_setting();
    test_random_typing(RANDOM_ITEMS / 3);
    write_lf(ADDR_LF_AFTER_ENTER, 1'b0);
    test_random_typing(RANDOM_ITEMS / 3);
    write_lf(ADDR_LF_AFTER_ENTER, 1'b1);
    test_random_typing(RANDOM_ITEMS / 3);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("hid_keyboard_report_decoder_unit: match");
    end else begin
      $display("hid_keyboard_report_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
